@@ rtl/htfd_pkg.sv @@
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared constants, types and the byte-wise CRC-8 step for the sensor reply
// frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  // Frame layout
  localparam int unsigned PAYLOAD_DEPTH = 5;
  localparam logic [2:0]  CRC_BYTES     = 3'd6;
  localparam logic [2:0]  POS_FIRST     = 3'd0;

  // CRC-8, poly 0x31, init 0xFF, MSB first, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Raw field layout and scaling
  localparam int unsigned RAW_W      = 20;
  localparam logic [3:0]  LOW_NIBBLE = 4'hF;
  localparam int unsigned HUM_W      = 10;
  localparam int unsigned TEMP_W     = 11;
  localparam int unsigned TEMP_OUT_W = 12;
  localparam logic [9:0]  HUMI_SCALE = 10'd1000;
  localparam logic [10:0] TEMP_SCALE = 11'd2000;
  localparam logic [TEMP_OUT_W-1:0] TEMP_OFFSET = 12'd500;

  typedef logic [7:0] byte_t;
  typedef logic [HUM_W-1:0] hum_t;
  typedef logic [TEMP_W-1:0] temp_t;

  // One byte through the CRC register, eight shift steps
  function automatic byte_t crc8_feed(input byte_t crc, input byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/htfd_convert.sv @@
// ----------------------------------------------------------------------------
// htfd_convert
// Unpacks the two 20-bit raw fields from payload bytes 1 to 5 and scales them
// to tenths of a percent and (offset-free) tenths of a degree.
// ----------------------------------------------------------------------------
module htfd_convert (
  input  htfd_pkg::byte_t payload [htfd_pkg::PAYLOAD_DEPTH],
  output htfd_pkg::hum_t  humidity,
  output htfd_pkg::temp_t temperature
);

  logic [htfd_pkg::RAW_W-1:0] raw_hum;
  logic [htfd_pkg::RAW_W-1:0] raw_temp;
  logic [29:0]                hum_prod;
  logic [30:0]                temp_prod;

  // Field unpack: humidity is the upper 20 bits, temperature the lower 20
  assign raw_hum  = {payload[0], payload[1], payload[2][7:4]};
  assign raw_temp = {payload[2][3:0] & htfd_pkg::LOW_NIBBLE, payload[3], payload[4]};

  // raw * scale / 2^20, keep the integer part
  assign hum_prod  = 30'(raw_hum) * 30'(htfd_pkg::HUMI_SCALE);
  assign temp_prod = 31'(raw_temp) * 31'(htfd_pkg::TEMP_SCALE);

  assign humidity    = hum_prod[29:20];
  assign temperature = temp_prod[30:20];

endmodule

@@ rtl/humidity_temp_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Decodes a seven-byte humidity/temperature sensor reply with CRC-8 check.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one reply byte per item; in_frame_start marks byte 0 and drops any
//           partial reply. Without it, positions advance 0..6 and wrap.
//   out_* : one item after each checksum byte (byte 6): crc_ok, the CRC over
//           bytes 0 to 5, and the held humidity/temperature in tenths. A
//           matching checksum updates the held values first; a mismatch
//           leaves them. Bytes 0 to 5 produce no output item.
//   Path: an input byte is registered, then decoded into the output register.
//   Throughput: one byte per cycle when not stalled; the CRC step sits between
//   the input and CRC registers, and the two constant multiplies between the
//   payload registers and the output register.
//   Stall: while an output item waits on out_ready, the decode stage holds
//   and in_ready drops once the input register is occupied.
//   Reset: position 0, CRC 0xFF, held humidity 0, held temperature -50.0 deg.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_frame_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_crc_ok,
  output logic [7:0]             out_computed_crc,
  output logic [9:0]             out_humidity_tenths,
  output logic signed [11:0]     out_temperature_tenths
);

  // Input register
  logic            s1_valid_r;
  htfd_pkg::byte_t s1_byte_r;
  logic            s1_start_r;

  // Frame state
  logic [2:0]      pos_r;
  htfd_pkg::byte_t crc_r;
  htfd_pkg::byte_t payload_r [htfd_pkg::PAYLOAD_DEPTH];
  htfd_pkg::hum_t  held_hum_r;
  htfd_pkg::temp_t held_temp_r;

  // Output register
  logic            out_valid_r;
  logic            out_ok_r;
  htfd_pkg::byte_t out_crc_r;
  htfd_pkg::hum_t  out_hum_r;
  logic [htfd_pkg::TEMP_OUT_W-1:0] out_temp_r;

  // Decode stage signals
  logic            s1_go;
  logic [2:0]      pos_cur;
  logic [2:0]      pay_idx;
  logic            is_check;
  logic            crc_match;
  htfd_pkg::byte_t crc_base;
  htfd_pkg::byte_t crc_fed;
  htfd_pkg::hum_t  hum_scaled;
  htfd_pkg::temp_t temp_scaled;
  htfd_pkg::hum_t  held_hum_nxt;
  htfd_pkg::temp_t held_temp_nxt;

  // Handshake: decode stage moves whenever the output slot is free or draining
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_frame_start;
    end
  end

  // Position and CRC for the byte in the decode stage
  always_comb begin
    pos_cur   = s1_start_r ? htfd_pkg::POS_FIRST : pos_r;
    pay_idx   = pos_cur - 3'd1;
    is_check  = (pos_cur >= htfd_pkg::CRC_BYTES);
    crc_base  = (pos_cur == htfd_pkg::POS_FIRST) ? htfd_pkg::CRC_INIT : crc_r;
    crc_fed   = htfd_pkg::crc8_feed(crc_base, s1_byte_r);
    crc_match = (s1_byte_r == crc_r);
  end

  htfd_convert u_convert (
    .payload     (payload_r),
    .humidity    (hum_scaled),
    .temperature (temp_scaled)
  );

  // Held values change only on a good checksum
  always_comb begin
    held_hum_nxt  = held_hum_r;
    held_temp_nxt = held_temp_r;
    if (is_check && crc_match) begin
      held_hum_nxt  = hum_scaled;
      held_temp_nxt = temp_scaled;
    end
  end

  // Frame state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= htfd_pkg::POS_FIRST;
      crc_r       <= htfd_pkg::CRC_INIT;
      held_hum_r  <= '0;
      held_temp_r <= '0;
    end else if (s1_go) begin
      if (is_check) begin
        pos_r       <= htfd_pkg::POS_FIRST;
        crc_r       <= htfd_pkg::CRC_INIT;
        held_hum_r  <= held_hum_nxt;
        held_temp_r <= held_temp_nxt;
      end else begin
        pos_r <= pos_cur + 3'd1;
        crc_r <= crc_fed;
      end
    end
  end

  // Payload bytes 1 to 5
  always_ff @(posedge clk) begin
    if (s1_go && !is_check && (pos_cur != htfd_pkg::POS_FIRST)) begin
      payload_r[pay_idx] <= s1_byte_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && is_check) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && is_check) begin
      out_ok_r   <= crc_match;
      out_crc_r  <= crc_r;
      out_hum_r  <= held_hum_nxt;
      out_temp_r <= {1'b0, held_temp_nxt} - htfd_pkg::TEMP_OFFSET;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_crc_ok             = out_ok_r;
  assign out_computed_crc       = out_crc_r;
  assign out_humidity_tenths    = out_hum_r;
  assign out_temperature_tenths = $signed(out_temp_r);

endmodule

@@ rtl/htfd_checker.sv @@
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level checks for the sensor reply frame decoder, bound to the top.
// ----------------------------------------------------------------------------
module htfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_crc_ok,
  input logic [7:0]         out_computed_crc,
  input logic [9:0]         out_humidity_tenths,
  input logic signed [11:0] out_temperature_tenths
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_crc_ok) && $stable(out_computed_crc) &&
      $stable(out_humidity_tenths) && $stable(out_temperature_tenths))
    else $error("output payload changed while stalled");

  // Scaled humidity never reaches 100.0 percent
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_tenths <= 10'd999)
    else $error("humidity out of range");

  // Temperature stays within -50.0 .. 149.9 degrees
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_tenths >= -12'sd500) &&
      (out_temperature_tenths <= 12'sd1499))
    else $error("temperature out of range");

endmodule

bind humidity_temp_frame_decoder_top htfd_checker u_htfd_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_crc_ok             (out_crc_ok),
  .out_computed_crc       (out_computed_crc),
  .out_humidity_tenths    (out_humidity_tenths),
  .out_temperature_tenths (out_temperature_tenths)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sensor reply frame decoder. A queue-fed driver
// sends reply bytes in random bursts, and a behavioral decoder predicts every
// reading. A monitor under a changing back-pressure pattern compares each
// reading field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int TARGET_ITEMS = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [htfd_pkg::TEMP_OUT_W-1:0] temp_out_t;

  // One received byte as it goes on the input channel
  typedef struct packed {
    htfd_pkg::byte_t data;
    logic            start;
  } rx_byte_t;

  // One decoded reading as it leaves the output channel
  typedef struct packed {
    logic            crc_ok;
    htfd_pkg::byte_t crc;
    htfd_pkg::hum_t  humidity;
    temp_out_t       temperature;
  } reading_t;

  logic clk;
  logic rst_n = 1'b0;

  logic            in_valid = 1'b0;
  logic            in_ready;
  htfd_pkg::byte_t in_data_byte = '0;
  logic            in_frame_start = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            out_crc_ok;
  htfd_pkg::byte_t out_computed_crc;
  htfd_pkg::hum_t  out_humidity_tenths;
  temp_out_t       out_temperature_tenths;

  rx_byte_t pending_bytes[$];
  reading_t readings_due[$];

  // Decoder shadow state
  logic [2:0]      frame_pos;
  htfd_pkg::byte_t crc_acc;
  htfd_pkg::byte_t payload [htfd_pkg::PAYLOAD_DEPTH];
  htfd_pkg::hum_t  hold_hum;
  htfd_pkg::temp_t hold_temp;

  int queued_items   = 0;
  int bytes_taken    = 0;
  int readings_seen  = 0;
  int frames_matched = 0;
  int frames_failed  = 0;
  int resyncs        = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  int burst_left = 0;
  int gap_left   = 0;
  int stall_period = 1;
  int stall_open   = 1;
  int stall_phase  = 0;
  int stall_hold   = 0;

  humidity_temp_frame_decoder_top uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_frame_start         (in_frame_start),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_crc_ok             (out_crc_ok),
    .out_computed_crc       (out_computed_crc),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_tenths (out_temperature_tenths)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Serial CRC-8: feedback is the top register bit xor the incoming data bit
  function automatic htfd_pkg::byte_t crc8_next(input htfd_pkg::byte_t crc,
                                                input htfd_pkg::byte_t b);
    htfd_pkg::byte_t r;
    logic            fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ htfd_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  // Advance the shadow decoder by one accepted byte
  task automatic decode_byte(input htfd_pkg::byte_t b, input logic start);
    logic [htfd_pkg::RAW_W-1:0] raw_hum;
    logic [htfd_pkg::RAW_W-1:0] raw_temp;
    logic [31:0]                scaled;
    reading_t                   r;
    if (start) begin
      if (frame_pos != htfd_pkg::POS_FIRST) begin
        resyncs++;
      end
      frame_pos = htfd_pkg::POS_FIRST;
      crc_acc = htfd_pkg::CRC_INIT;
    end
    if (frame_pos < htfd_pkg::CRC_BYTES) begin
      if (frame_pos == htfd_pkg::POS_FIRST) begin
        crc_acc = htfd_pkg::CRC_INIT;
      end
      crc_acc = crc8_next(crc_acc, b);
      if (frame_pos != htfd_pkg::POS_FIRST) begin
        payload[frame_pos - 3'd1] = b;
      end
      frame_pos = frame_pos + 3'd1;
    end else begin
      // checksum byte: one reading, held values move only on a match
      r.crc_ok = (b == crc_acc);
      r.crc = crc_acc;
      if (r.crc_ok) begin
        raw_hum  = {payload[0], payload[1], payload[2][7:4]};
        raw_temp = {payload[2][3:0], payload[3], payload[4]};
        scaled = raw_hum * htfd_pkg::HUMI_SCALE;
        hold_hum = scaled[htfd_pkg::RAW_W +: htfd_pkg::HUM_W];
        scaled = raw_temp * htfd_pkg::TEMP_SCALE;
        hold_temp = scaled[htfd_pkg::RAW_W +: htfd_pkg::TEMP_W];
        frames_matched++;
      end else begin
        frames_failed++;
      end
      r.humidity = hold_hum;
      r.temperature = {1'b0, hold_temp} - htfd_pkg::TEMP_OFFSET;
      readings_due.push_back(r);
      frame_pos = htfd_pkg::POS_FIRST;
      crc_acc = htfd_pkg::CRC_INIT;
    end
  endtask

  // Queue a full seven-byte reply, with a good or a corrupted checksum
  task automatic queue_frame(input htfd_pkg::byte_t body [6], input logic good,
                             input logic mark);
    htfd_pkg::byte_t crc;
    htfd_pkg::byte_t chk;
    crc = htfd_pkg::CRC_INIT;
    for (int k = 0; k < 6; k++) begin
      crc = crc8_next(crc, body[k]);
      pending_bytes.push_back('{body[k], mark && (k == 0)});
    end
    chk = good ? crc : crc ^ htfd_pkg::byte_t'($urandom_range(1, 255));
    pending_bytes.push_back('{chk, 1'b0});
    queued_items += 7;
  endtask

  function automatic htfd_pkg::byte_t pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return 8'h00;
    end else if (sel == 1) begin
      return 8'hFF;
    end
    return htfd_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  // Wait until the bench is quiet: nothing queued, nothing in flight
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || readings_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    rx_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= '0;
      in_frame_start <= 1'b0;
      frame_pos = htfd_pkg::POS_FIRST;
      crc_acc = htfd_pkg::CRC_INIT;
      hold_hum = '0;
      hold_temp = '0;
      for (int k = 0; k < htfd_pkg::PAYLOAD_DEPTH; k++) begin
        payload[k] = '0;
      end
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte, in_frame_start);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0 || pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) begin
            gap_left--;
          end
        end else begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= nxt.data;
          in_frame_start <= nxt.start;
          burst_left--;
        end
      end
    end
  end

  // Receiver back-pressure: a random duty pattern, redrawn after each hold interval
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_hold = $urandom_range(100, 300);
      stall_period = $urandom_range(1, 8);
      stall_open = ($urandom_range(0, 3) == 0) ? stall_period
                                               : $urandom_range(1, stall_period);
      stall_phase = 0;
    end
    stall_hold--;
    out_ready <= (stall_phase < stall_open);
    stall_phase = (stall_phase + 1) % stall_period;
  end

  // Monitor: each accepted reading against the oldest prediction
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      readings_seen++;
      if (readings_due.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected reading: crc_ok=%0b crc=%02h hum=%0d temp=%0d",
                   out_crc_ok, out_computed_crc, out_humidity_tenths,
                   $signed(out_temperature_tenths));
        end
        mismatches++;
      end else begin
        exp_r = readings_due.pop_front();
        if (out_crc_ok !== exp_r.crc_ok || out_computed_crc !== exp_r.crc ||
            out_humidity_tenths !== exp_r.humidity ||
            out_temperature_tenths !== exp_r.temperature) begin
          if (mismatches < MAX_REPORTS) begin
            $display("reading %0d mismatch: exp crc_ok=%0b crc=%02h hum=%0d temp=%0d",
                     readings_seen, exp_r.crc_ok, exp_r.crc, exp_r.humidity,
                     $signed(exp_r.temperature));
            $display("                      got crc_ok=%0b crc=%02h hum=%0d temp=%0d",
                     out_crc_ok, out_computed_crc, out_humidity_tenths,
                     $signed(out_temperature_tenths));
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding",
               cycle_count, readings_due.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    htfd_pkg::byte_t body [6];
    int              pick;
    int              n;

    // Before any valid frame: zero body, bad checksum, held values still at reset
    body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    queue_frame(body, 1'b0, 1'b1);
    // Free-running: no start flag, position wraps after the checksum; full scale
    body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    queue_frame(body, 1'b1, 1'b0);
    // Partial reply dropped by a resync, then a good all-zero frame
    pending_bytes.push_back('{8'hA5, 1'b1});
    pending_bytes.push_back('{8'h5A, 1'b0});
    pending_bytes.push_back('{8'hFF, 1'b0});
    queued_items += 3;
    body = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    queue_frame(body, 1'b1, 1'b1);

    // Hold the sender until every directed reading has come back
    drain();

    // Random: mostly well-formed frames, some truncated replies and noise
    while (queued_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        for (int k = 0; k < 6; k++) begin
          body[k] = pick_byte();
        end
        queue_frame(body, $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0);
      end else if (pick < 90) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          pending_bytes.push_back('{pick_byte(), k == 0});
        end
        queued_items += n;
      end else begin
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          pending_bytes.push_back('{htfd_pkg::byte_t'($urandom_range(0, 255)),
                                    $urandom_range(0, 3) == 0});
        end
        queued_items += n;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d reply bytes, %0d resyncs mid-reply", bytes_taken, resyncs);
    $display("checked %0d readings: %0d checksum matches, %0d mismatches, %0d errors",
             readings_seen, frames_matched, frames_failed, mismatches);
    if (readings_due.size() != 0) begin
      $display("%0d predicted readings never arrived", readings_due.size());
    end
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
